### rtl/core/tiny_language_lexer_macros.svh
// assertion macros used by the lexer checker
`ifndef TINY_LANGUAGE_LEXER_MACROS_SVH
`define TINY_LANGUAGE_LEXER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tll_pkg.sv
// shared constants, types and helpers of the lexer
`timescale 1ns / 1ps
`default_nettype none
package tll_pkg;

	localparam int MAX_TEXT = 40;
	localparam int ADDR_W   = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam int LEN_W    = $clog2(MAX_TEXT + 1);
	localparam int POS_W    = 6;
	localparam int TYPE_W   = 4;
	localparam int BYTE_W   = 8;

	// token type codes
	localparam logic [TYPE_W-1:0] TK_UNKNOWN = 4'd0;
	localparam logic [TYPE_W-1:0] TK_NUM     = 4'd1;
	localparam logic [TYPE_W-1:0] TK_ID      = 4'd2;
	localparam logic [TYPE_W-1:0] TK_ASSIGN  = 4'd3;
	localparam logic [TYPE_W-1:0] TK_PLUS    = 4'd4;
	localparam logic [TYPE_W-1:0] TK_MINUS   = 4'd5;
	localparam logic [TYPE_W-1:0] TK_TIMES   = 4'd6;
	localparam logic [TYPE_W-1:0] TK_DIVIDE  = 4'd7;
	localparam logic [TYPE_W-1:0] TK_EQUAL   = 4'd8;
	localparam logic [TYPE_W-1:0] TK_LESS    = 4'd9;
	localparam logic [TYPE_W-1:0] TK_LPAREN  = 4'd10;
	localparam logic [TYPE_W-1:0] TK_RPAREN  = 4'd11;
	localparam logic [TYPE_W-1:0] TK_SEMI    = 4'd12;
	localparam logic [TYPE_W-1:0] TK_ENDFILE = 4'd13;

	// character codes
	localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_LESS   = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_DIG0   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIG9   = 8'h39;
	localparam logic [BYTE_W-1:0] LETTER_LO = 8'd65;
	localparam logic [BYTE_W-1:0] LETTER_HI = 8'd122;
	localparam logic [BYTE_W-1:0] WS_LF     = 8'd10;
	localparam logic [BYTE_W-1:0] WS_SPACE  = 8'd32;
	localparam logic [BYTE_W-1:0] WS_NUL    = 8'd0;
	localparam logic [BYTE_W-1:0] WS_VT     = 8'd11;

	// datapath commands from the controller
	typedef struct packed {
		logic                latch;
		logic                sel_latched;
		logic                append;
		logic                load_type;
		logic [TYPE_W-1:0]   tok_type;
		logic                issue;
		logic                clear_len;
		logic                eof_issue;
	} dp_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic                is_space;
		logic                is_lbrace;
		logic                is_rbrace;
		logic                is_letter;
		logic                is_digit;
		logic                is_colon;
		logic                is_equal;
		logic                cur_end;
		logic [TYPE_W-1:0]   sym_type;
		logic                issue_ok;
		logic                len_zero;
		logic                last_idx;
	} dp_status_t;

	function automatic logic [TYPE_W-1:0] symbol_type(input logic [BYTE_W-1:0] c);
		logic [TYPE_W-1:0] t;
		case (c)
			CH_PLUS:   t = TK_PLUS;
			CH_MINUS:  t = TK_MINUS;
			CH_STAR:   t = TK_TIMES;
			CH_SLASH:  t = TK_DIVIDE;
			CH_EQUAL:  t = TK_EQUAL;
			CH_LESS:   t = TK_LESS;
			CH_LPAREN: t = TK_LPAREN;
			CH_RPAREN: t = TK_RPAREN;
			CH_SEMI:   t = TK_SEMI;
			default:   t = TK_UNKNOWN;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

### rtl/core/tll_ifs.sv
// valid/ready channel interfaces for source bytes and token text
`timescale 1ns / 1ps
`default_nettype none
interface tll_in_if;
	logic                          valid;
	logic                          ready;
	logic [tll_pkg::BYTE_W-1:0]    char_byte;
	logic                          end_of_input;

	modport source (output valid, output char_byte, output end_of_input, input ready);
	modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface tll_out_if;
	logic                          valid;
	logic                          ready;
	logic [tll_pkg::TYPE_W-1:0]    token_type;
	logic [tll_pkg::BYTE_W-1:0]    text_byte;
	logic                          text_valid;
	logic [tll_pkg::POS_W-1:0]     text_position;
	logic                          last_of_token;

	modport source (output valid, output token_type, output text_byte, output text_valid,
		output text_position, output last_of_token, input ready);
	modport sink   (input valid, input token_type, input text_byte, input text_valid,
		input text_position, input last_of_token, output ready);
endinterface
`default_nettype wire

### rtl/core/tiny_language_lexer.sv
// top level of the character-at-a-time lexer
//
//   channel   direction  handshake     payload
//   in_ch     sink       valid/ready   char_byte, end_of_input
//   out_ch    source     valid/ready   token_type, text_byte, text_valid,
//                                      text_position, last_of_token
//
// a byte that extends a token (or is whitespace or comment) is taken in SEQ_IDLE
// a finished token streams its text at one byte per cycle while out_ch is not
//   stalled, set by the single read port of the token buffer; SEQ_RESTART then
//   rescans an ending byte that was not part of the token, and issues endfile
// buffer reads pass through the s1 registers to the output register; input is
//   taken while earlier text still drains, but not during a token stream
// no clearing pass after reset; a stalled out_ch backs up into the read pipe
`timescale 1ns / 1ps
`default_nettype none
module tiny_language_lexer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tll_in_if.sink     in_ch,
	tll_out_if.source  out_ch
);
	import tll_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencing and scan state: decides what each transfer does to the buffer
	tll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// classes the current byte, keeps the token text and streams it out
	tll_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_byte        (in_ch.char_byte),
		.in_end         (in_ch.end_of_input),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_type       (out_ch.token_type),
		.out_byte       (out_ch.text_byte),
		.out_text_valid (out_ch.text_valid),
		.out_pos        (out_ch.text_position),
		.out_last       (out_ch.last_of_token)
	);

endmodule
`default_nettype wire

### rtl/core/tll_datapath.sv
// token buffer, character classes, read pipe and output register
`timescale 1ns / 1ps
`default_nettype none
module tll_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [tll_pkg::BYTE_W-1:0]  in_byte,
	input  wire logic                        in_end,
	input  wire tll_pkg::dp_cmd_t            cmd,
	output tll_pkg::dp_status_t              status,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [tll_pkg::TYPE_W-1:0]       out_type,
	output logic [tll_pkg::BYTE_W-1:0]       out_byte,
	output logic                             out_text_valid,
	output logic [tll_pkg::POS_W-1:0]        out_pos,
	output logic                             out_last
);
	import tll_pkg::*;

	logic [BYTE_W-1:0] byte_q;
	logic              end_q;
	logic [BYTE_W-1:0] cur;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] rd_idx_q;
	logic [TYPE_W-1:0] ttype_q;
	logic [BYTE_W-1:0] mem [MAX_TEXT];

	logic              valid_s1;
	logic              eof_s1;
	logic [BYTE_W-1:0] rdata_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              last_s1;
	logic [TYPE_W-1:0] type_s1;

	logic              ov_q;
	logic              out_free;
	logic              room;

	assign cur      = cmd.sel_latched ? byte_q : in_byte;
	assign out_free = !ov_q || out_ready;
	assign room     = len_q < LEN_W'(MAX_TEXT);

	always_comb begin
		status           = '0;
		status.is_space  = cur inside {WS_LF, WS_SPACE, WS_NUL, WS_VT};
		status.is_lbrace = cur == CH_LBRACE;
		status.is_rbrace = cur == CH_RBRACE;
		status.is_letter = cur inside {[LETTER_LO:LETTER_HI]};
		status.is_digit  = cur inside {[CH_DIG0:CH_DIG9]};
		status.is_colon  = cur == CH_COLON;
		status.is_equal  = cur == CH_EQUAL;
		status.cur_end   = cmd.sel_latched ? end_q : in_end;
		status.sym_type  = symbol_type(cur);
		status.issue_ok  = !valid_s1 || out_free;
		status.len_zero  = len_q == '0;
		status.last_idx  = (LEN_W'(rd_idx_q) + LEN_W'(1)) == len_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (cmd.clear_len) begin
				len_q <= '0;
			end else if (cmd.append && room) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (cmd.issue) begin
				rd_idx_q <= cmd.clear_len ? '0 : rd_idx_q + ADDR_W'(1);
			end
			if (cmd.issue || cmd.eof_issue) begin
				valid_s1 <= 1'b1;
			end else if (valid_s1 && out_free) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && out_free) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// token text buffer
	always_ff @(posedge clk) begin
		if (cmd.append && room) begin
			mem[len_q[ADDR_W-1:0]] <= cur;
		end
		if (cmd.issue) begin
			rdata_s1 <= mem[rd_idx_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= in_byte;
			end_q  <= in_end;
		end
		if (cmd.load_type) begin
			ttype_q <= cmd.tok_type;
		end
		if (cmd.issue || cmd.eof_issue) begin
			eof_s1  <= cmd.eof_issue;
			pos_s1  <= cmd.eof_issue ? '0 : POS_W'(rd_idx_q);
			last_s1 <= cmd.eof_issue ? 1'b1 : status.last_idx;
			type_s1 <= cmd.eof_issue ? TK_ENDFILE : ttype_q;
		end
		if (valid_s1 && out_free) begin
			out_type       <= type_s1;
			out_byte       <= eof_s1 ? '0 : rdata_s1;
			out_text_valid <= !eof_s1;
			out_pos        <= pos_s1;
			out_last       <= last_s1;
		end
	end

	assign out_valid = ov_q;

endmodule
`default_nettype wire

### rtl/core/tll_ctrl.sv
// sequencer and scan state machine of the lexer
`timescale 1ns / 1ps
`default_nettype none
module tll_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire tll_pkg::dp_status_t  status,
	output tll_pkg::dp_cmd_t          cmd
);
	import tll_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE    = 3'b001,
		SEQ_EMIT    = 3'b010,
		SEQ_RESTART = 3'b100
	} seq_t;

	typedef enum logic [4:0] {
		SCAN_START   = 5'b00001,
		SCAN_COMMENT = 5'b00010,
		SCAN_NUM     = 5'b00100,
		SCAN_ID      = 5'b01000,
		SCAN_COLON   = 5'b10000
	} scan_t;

	seq_t  seq_q, seq_d;
	scan_t scan_q, scan_d;
	logic  follow_q, follow_d;
	logic  start_act;

	always_comb begin
		cmd       = '0;
		seq_d     = seq_q;
		scan_d    = scan_q;
		follow_d  = follow_q;
		in_ready  = 1'b0;
		start_act = 1'b0;
		case (seq_q)
			SEQ_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (scan_q)
						SCAN_COMMENT: begin
							if (status.cur_end) begin
								scan_d = SCAN_START;
								seq_d  = SEQ_RESTART;
							end else if (status.is_rbrace) begin
								scan_d = SCAN_START;
							end
						end
						SCAN_NUM: begin
							if (!status.cur_end && status.is_digit) begin
								cmd.append = 1'b1;
							end else begin
								cmd.load_type = 1'b1;
								cmd.tok_type  = TK_NUM;
								seq_d         = SEQ_EMIT;
								follow_d      = 1'b1;
								scan_d        = SCAN_START;
							end
						end
						SCAN_ID: begin
							if (!status.cur_end && status.is_letter) begin
								cmd.append = 1'b1;
							end else begin
								cmd.load_type = 1'b1;
								cmd.tok_type  = TK_ID;
								seq_d         = SEQ_EMIT;
								follow_d      = 1'b1;
								scan_d        = SCAN_START;
							end
						end
						SCAN_COLON: begin
							cmd.load_type = 1'b1;
							seq_d         = SEQ_EMIT;
							scan_d        = SCAN_START;
							if (!status.cur_end && status.is_equal) begin
								cmd.append   = 1'b1;
								cmd.tok_type = TK_ASSIGN;
								follow_d     = 1'b0;
							end else begin
								cmd.tok_type = TK_UNKNOWN;
								follow_d     = 1'b1;
							end
						end
						default: begin
							scan_d = SCAN_START;
							if (status.cur_end) begin
								seq_d = SEQ_RESTART;
							end else begin
								start_act = 1'b1;
							end
						end
					endcase
				end
			end
			SEQ_EMIT: begin
				if (status.len_zero) begin
					seq_d = follow_q ? SEQ_RESTART : SEQ_IDLE;
				end else if (status.issue_ok) begin
					cmd.issue = 1'b1;
					if (status.last_idx) begin
						cmd.clear_len = 1'b1;
						seq_d         = follow_q ? SEQ_RESTART : SEQ_IDLE;
					end
				end
			end
			SEQ_RESTART: begin
				cmd.sel_latched = 1'b1;
				if (status.cur_end) begin
					if (status.issue_ok) begin
						cmd.eof_issue = 1'b1;
						seq_d         = SEQ_IDLE;
					end
				end else begin
					start_act = 1'b1;
					seq_d     = SEQ_IDLE;
				end
			end
			default: begin
				seq_d = SEQ_IDLE;
			end
		endcase

		// first byte of a token, from the start state
		if (start_act && !status.is_space) begin
			if (status.is_lbrace) begin
				scan_d = SCAN_COMMENT;
			end else if (status.is_letter) begin
				scan_d     = SCAN_ID;
				cmd.append = 1'b1;
			end else if (status.is_digit) begin
				scan_d     = SCAN_NUM;
				cmd.append = 1'b1;
			end else if (status.is_colon) begin
				scan_d     = SCAN_COLON;
				cmd.append = 1'b1;
			end else begin
				cmd.append    = 1'b1;
				cmd.load_type = 1'b1;
				cmd.tok_type  = status.sym_type;
				seq_d         = SEQ_EMIT;
				follow_d      = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= SEQ_IDLE;
			scan_q   <= SCAN_START;
			follow_q <= 1'b0;
		end else begin
			seq_q    <= seq_d;
			scan_q   <= scan_d;
			follow_q <= follow_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/tll_checker.sv
// port-level checks of the lexer output stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "tiny_language_lexer_macros.svh"
module tll_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic [tll_pkg::TYPE_W-1:0]  token_type,
	input  wire logic [tll_pkg::BYTE_W-1:0]  text_byte,
	input  wire logic                        text_valid,
	input  wire logic [tll_pkg::POS_W-1:0]   text_position,
	input  wire logic                        last_of_token
);
	import tll_pkg::*;

	// stalled transfer keeps its payload
	`TLL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(token_type) && $stable(text_byte) && $stable(text_position) && $stable(last_of_token), "output changed while stalled")

	// a textless item is a lone endfile
	`TLL_ASSERT_NOW(a_eof_shape, clk, arst_n, out_valid && !text_valid, token_type == TK_ENDFILE && last_of_token && text_position == '0, "malformed endfile item")

	// token text streams without gaps, positions counting up
	`TLL_ASSERT_NEXT(a_text_run, clk, arst_n, out_valid && out_ready && !last_of_token, out_valid && text_valid && token_type == $past(token_type) && text_position == $past(text_position) + POS_W'(1), "token text not contiguous")

endmodule

bind tiny_language_lexer tll_checker u_tll_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.token_type    (out_ch.token_type),
	.text_byte     (out_ch.text_byte),
	.text_valid    (out_ch.text_valid),
	.text_position (out_ch.text_position),
	.last_of_token (out_ch.last_of_token)
);
`default_nettype wire
